[rtl/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg: shared constants for the adaptive pixel threshold core
// Frame geometry, field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;

    // position of a pixel, and a count that can reach PIXELS itself
    localparam int POS_W = $clog2(PIXELS);
    localparam int HWM_W = $clog2(PIXELS + 1);

    localparam int CHAN_W  = 8;
    localparam int LUM_W   = 10;
    localparam int LEVEL_W = 10;
    localparam int COUNT_W = 19;
    localparam int MU_W    = 16;
    localparam int OFS_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MU_Q16       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_MARGIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_OFFSET  = 2'd3;

    localparam logic [MU_W-1:0]    MU_Q16_RST       = 16'd655;
    localparam logic [LUM_W-1:0]   BRIGHT_FLOOR_RST = 10'd220;
    localparam logic [LUM_W-1:0]   DARK_MARGIN_RST  = 10'd5;
    localparam logic [OFS_W-1:0]   RISE_OFFSET_RST  = 8'd15;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;

endpackage

`default_nettype wire

[rtl/apt_pix_if.sv]
// ----------------------------------------------------------------------------
// apt_pix_if: pixel input channel
// Valid/ready channel carrying three color channels and a frame start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface apt_pix_if;

    logic                       valid;
    logic                       ready;
    logic [apt_pkg::CHAN_W-1:0] chan_blue;
    logic [apt_pkg::CHAN_W-1:0] chan_green;
    logic [apt_pkg::CHAN_W-1:0] chan_red;
    logic                       start_of_frame;

    modport source (
        output valid,
        output chan_blue,
        output chan_green,
        output chan_red,
        output start_of_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  chan_blue,
        input  chan_green,
        input  chan_red,
        input  start_of_frame,
        output ready
    );

endinterface

`default_nettype wire

[rtl/apt_res_if.sv]
// ----------------------------------------------------------------------------
// apt_res_if: classification result channel
// Valid/ready channel carrying the white flag, frame white count and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

interface apt_res_if;

    logic                        valid;
    logic                        ready;
    logic                        is_white;
    logic [apt_pkg::COUNT_W-1:0] white_count;
    logic                        end_of_frame;

    modport source (
        output valid,
        output is_white,
        output white_count,
        output end_of_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  is_white,
        input  white_count,
        input  end_of_frame,
        output ready
    );

endinterface

`default_nettype wire

[rtl/adaptive_pixel_threshold_core.sv]
// Path: an accepted pixel beat moves through stages 1, 2 and 3 into the output register.
// Throughput: one pixel per cycle while results are taken; a beat waits while its frame position is still
//   in flight in the first three stages (frame restarted within three pixels),
//   since the level store is read at accept and written as the item leaves stage 3.
// Reset: registers return to defaults, position and white count clear; the level
//   store reads as zero at and above a high-water mark of written positions, no clearing pass.
// ----------------------------------------------------------------------------
// adaptive_pixel_threshold_core: per-pixel adaptive background threshold
// Sums the color channels, compares against a stored per-position background
// level, classifies the pixel and adapts the level in a four-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_pixel_threshold_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    apt_pix_if.sink                               i_pix,
    apt_res_if.source                             o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [apt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import apt_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PIXELS - 1);

    // configuration
    logic [MU_W-1:0]    r_mu_q16;
    logic [LUM_W-1:0]   r_bright_floor;
    logic [LUM_W-1:0]   r_dark_margin;
    logic [OFS_W-1:0]   r_rise_offset;

    // frame state
    logic [POS_W-1:0]   r_pos;
    logic [HWM_W-1:0]   r_hwm;
    logic [COUNT_W-1:0] r_white_total;

    // level store
    logic [LEVEL_W-1:0] r_level_mem [PIXELS];
    logic [LEVEL_W-1:0] r_mem_rd;

    // stage 1
    logic               r_v1;
    logic [LUM_W-1:0]   r_lum1;
    logic [POS_W-1:0]   r_pos1;
    logic               r_hit1;

    // stage 2
    logic               r_v2;
    logic [LUM_W-1:0]   r_lum2;
    logic [POS_W-1:0]   r_pos2;
    logic [LEVEL_W-1:0] r_level2;
    logic               r_white2;
    logic               r_fall2;
    logic [12:0]        r_diff9_2;

    // stage 3
    logic               r_v3;
    logic [POS_W-1:0]   r_pos3;
    logic [LEVEL_W-1:0] r_level3;
    logic               r_white3;
    logic               r_fall3;
    logic [28:0]        r_prod_rise3;
    logic [25:0]        r_prod_fall3;

    // output register
    logic               r_out_valid;
    logic               r_out_white;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_eof;

    logic               adv;
    logic               hazard;
    logic               acc;
    logic [POS_W-1:0]   pos_in;
    logic [LUM_W-1:0]   lum_in;

    logic [LEVEL_W-1:0] level_s1;
    logic [LUM_W-1:0]   diff_s1;
    logic               white_s1;
    logic               fall_s1;

    logic [13:0]        rise_s3;
    logic [13:0]        sum_s3;
    logic [LEVEL_W-1:0] fall_amt_s3;
    logic [LEVEL_W-1:0] n_level;
    logic [COUNT_W-1:0] n_count;
    logic               wr_en;

    // ---------------- accept side ----------------
    always_comb begin
        adv = !r_out_valid || o_res.ready;
        pos_in = i_pix.start_of_frame ? '0 : r_pos;
        // hold off a beat whose position is still in flight
        hazard = (r_v1 && (r_pos1 == pos_in))
              || (r_v2 && (r_pos2 == pos_in))
              || (r_v3 && (r_pos3 == pos_in));
        i_pix.ready = adv && !hazard;
        acc = i_pix.valid && i_pix.ready;
        lum_in = LUM_W'(i_pix.chan_blue) + LUM_W'(i_pix.chan_green)
               + LUM_W'(i_pix.chan_red);
    end

    // ---------------- level store ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mem_rd <= r_level_mem[pos_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_level_mem[r_pos3] <= n_level;
        end
    end

    // ---------------- stage 2 logic: classify ----------------
    always_comb begin
        level_s1 = r_hit1 ? r_mem_rd : '0;
        diff_s1  = r_lum1 - level_s1;
        white_s1 = (r_lum1 > level_s1) && (r_lum1 > r_bright_floor);
        fall_s1  = (level_s1 > r_lum1) && ((level_s1 - r_lum1) > r_dark_margin);
    end

    // ---------------- output logic: new level and count ----------------
    always_comb begin
        rise_s3     = 14'(r_prod_rise3[28:16]) + 14'(r_rise_offset);
        sum_s3      = 14'(r_level3) + rise_s3;
        // ceiling of the Q16 product
        fall_amt_s3 = r_prod_fall3[25:16] + LEVEL_W'(|r_prod_fall3[15:0]);
        if (r_white3) begin
            n_level = (sum_s3 > 14'(LEVEL_MAX)) ? LEVEL_MAX : sum_s3[LEVEL_W-1:0];
        end else if (r_fall3) begin
            n_level = (fall_amt_s3 >= r_level3) ? '0 : r_level3 - fall_amt_s3;
        end else begin
            n_level = r_level3;
        end
        // position zero always opens a fresh count
        n_count = ((r_pos3 == '0) ? '0 : r_white_total) + COUNT_W'(r_white3);
        // write every position so the high-water mark covers it
        wr_en = r_v3 && adv;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_q16       <= MU_Q16_RST;
            r_bright_floor <= BRIGHT_FLOOR_RST;
            r_dark_margin  <= DARK_MARGIN_RST;
            r_rise_offset  <= RISE_OFFSET_RST;
            r_pos          <= '0;
            r_hwm          <= '0;
            r_white_total  <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MU_Q16:       r_mu_q16       <= i_cfg_data[MU_W-1:0];
                    REG_BRIGHT_FLOOR: r_bright_floor <= i_cfg_data[LUM_W-1:0];
                    REG_DARK_MARGIN:  r_dark_margin  <= i_cfg_data[LUM_W-1:0];
                    REG_RISE_OFFSET:  r_rise_offset  <= i_cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_pos <= (pos_in == POS_LAST) ? '0 : pos_in + 1'b1;
            end
            if (wr_en) begin
                if (HWM_W'(r_pos3) == r_hwm) begin
                    r_hwm <= r_hwm + 1'b1;
                end
                r_white_total <= n_count;
            end
            if (adv) begin
                r_v1        <= acc;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_out_valid <= r_v3;
            end
        end
    end

    // ---------------- payload pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lum1       <= lum_in;
            r_pos1       <= pos_in;
            r_hit1       <= HWM_W'(pos_in) < r_hwm;

            r_lum2       <= r_lum1;
            r_pos2       <= r_pos1;
            r_level2     <= level_s1;
            r_white2     <= white_s1;
            r_fall2      <= fall_s1;
            r_diff9_2    <= {diff_s1, 3'b000} + 13'(diff_s1);

            r_pos3       <= r_pos2;
            r_level3     <= r_level2;
            r_white3     <= r_white2;
            r_fall3      <= r_fall2;
            r_prod_rise3 <= 29'(r_diff9_2) * 29'(r_mu_q16);
            r_prod_fall3 <= 26'(r_lum2) * 26'(r_mu_q16);

            r_out_white  <= r_white3;
            r_out_count  <= n_count;
            r_out_eof    <= (r_pos3 == POS_LAST);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.is_white     = r_out_white;
    assign o_res.white_count  = r_out_count;
    assign o_res.end_of_frame = r_out_eof;

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for adaptive_pixel_threshold_core
// Streams pixel beats through the core and checks every result beat against
// a local background-level tracker. Register settings change between phases
// while the core is idle. Both channels idle at random, and the result side
// holds off once long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb;

    import apt_pkg::*;

    localparam int unsigned RISE_GAIN   = 9;
    localparam int          PHASE_BEATS = 320;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          SHOWN_MAX   = 30;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              sof;
    } pixel_t;

    typedef struct packed {
        logic               is_white;
        logic [COUNT_W-1:0] white_count;
        logic               end_of_frame;
    } pix_class_t;

    // Tracks the background level of every position and predicts the class
    // of each accepted pixel.
    class bg_level_tracker;
        logic [MU_W-1:0]    mu;
        logic [LUM_W-1:0]   floor_lvl;
        logic [LUM_W-1:0]   margin;
        logic [OFS_W-1:0]   offset;
        logic [LEVEL_W-1:0] levels [int unsigned];
        int unsigned        position;
        int unsigned        whites;
        pix_class_t         pending_class [$];
        int                 mismatches;
        int                 n_pixels;
        int                 n_white;
        int                 n_drop;
        int                 n_eof;

        function new();
            mu         = MU_Q16_RST;
            floor_lvl  = BRIGHT_FLOOR_RST;
            margin     = DARK_MARGIN_RST;
            offset     = RISE_OFFSET_RST;
            position   = 0;
            whites     = 0;
            mismatches = 0;
            n_pixels   = 0;
            n_white    = 0;
            n_drop     = 0;
            n_eof      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MU_Q16:       mu        = data;
                REG_BRIGHT_FLOOR: floor_lvl = data[LUM_W-1:0];
                REG_DARK_MARGIN:  margin    = data[LUM_W-1:0];
                REG_RISE_OFFSET:  offset    = data[OFS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned next_level(bit sof);
            int unsigned pos;
            pos = (sof || position >= PIXELS) ? 0 : position;
            return levels.exists(pos) ? levels[pos] : 0;
        endfunction

        function void take_pixel(pixel_t p);
            int unsigned       lum;
            int unsigned       lvl;
            int unsigned       fall;
            longint unsigned   grown;
            pix_class_t        want;
            lum = int'(p.blue) + int'(p.green) + int'(p.red);
            if (p.sof || position >= PIXELS) begin
                position = 0;
                whites   = 0;
            end
            lvl  = levels.exists(position) ? levels[position] : 0;
            want = '0;
            if (lum > lvl && lum > floor_lvl) begin
                grown = lvl + ((longint'(lum - lvl) * RISE_GAIN * mu) >> 16) + offset;
                if (grown > LEVEL_MAX) grown = LEVEL_MAX;
                levels[position] = LEVEL_W'(grown);
                whites++;
                want.is_white = 1'b1;
                n_white++;
            end else if (lvl > lum && (lvl - lum) > margin) begin
                // round the drop up
                fall = (lum * mu + 32'd65535) >> 16;
                levels[position] = (fall >= lvl) ? '0 : LEVEL_W'(lvl - fall);
                n_drop++;
            end
            want.white_count = COUNT_W'(whites);
            if (position == PIXELS - 1) begin
                want.end_of_frame = 1'b1;
                position = 0;
                whites   = 0;
                n_eof++;
            end else begin
                position++;
            end
            n_pixels++;
            pending_class.push_back(want);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= SHOWN_MAX)
                $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void match_result(logic white, logic [COUNT_W-1:0] count, logic eof);
            pix_class_t want;
            if (pending_class.size() == 0) begin
                mismatches++;
                $error("result beat with no pixel outstanding: is_white %0d white_count %0d",
                       white, count);
                return;
            end
            want = pending_class.pop_front();
            if (white !== want.is_white)
                flag("is_white", 32'(want.is_white), 32'(white));
            if (count !== want.white_count)
                flag("white_count", 32'(want.white_count), 32'(count));
            if (eof !== want.end_of_frame)
                flag("end_of_frame", 32'(want.end_of_frame), 32'(eof));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    apt_pix_if pix ();
    apt_res_if res ();

    adaptive_pixel_threshold_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    bg_level_tracker tracker = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_taken;
    int hold_left;
    int quiet_cycles;
    int settings_used;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side: check each beat, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (res.valid && res.ready)
                tracker.match_result(res.is_white, res.white_count, res.end_of_frame);
            if (hold_requests != holds_taken) begin
                holds_taken <= hold_requests;
                hold_left   <= HOLD_CYCLES;
                res.ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic pixel_t px(int b, int g, int r, bit sof);
        pixel_t p;
        p.blue  = CHAN_W'(b);
        p.green = CHAN_W'(g);
        p.red   = CHAN_W'(r);
        p.sof   = sof;
        return p;
    endfunction

    function automatic pixel_t pixel_of_lum(int lum, bit sof);
        int b;
        int g;
        if (lum < 0) lum = 0;
        if (lum > 765) lum = 765;
        b = (lum > 255) ? 255 : lum;
        g = (lum - b > 255) ? 255 : lum - b;
        return px(b, g, lum - b - g, sof);
    endfunction

    function automatic int pick_chan();
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 255 : 0;
        return $urandom_range(255);
    endfunction

    function automatic pixel_t random_pixel(bit sof);
        int unsigned roll;
        int          lvl;
        roll = $urandom_range(99);
        lvl  = int'(tracker.next_level(sof));
        if (roll < 15)
            return pixel_of_lum(lvl - int'(tracker.margin) - 1 + int'($urandom_range(2)), sof);
        if (roll < 30)
            return pixel_of_lum(lvl - 1 + int'($urandom_range(2)), sof);
        if (roll < 40)
            return pixel_of_lum(int'(tracker.floor_lvl) - 1 + int'($urandom_range(2)), sof);
        return px(pick_chan(), pick_chan(), pick_chan(), sof);
    endfunction

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid          <= 1'b1;
        pix.chan_blue      <= p.blue;
        pix.chan_green     <= p.green;
        pix.chan_red       <= p.red;
        pix.start_of_frame <= p.sof;
        do @(posedge i_clk); while (!pix.ready);
        tracker.take_pixel(p);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (tracker.pending_class.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int mu, input int floor_lvl, input int margin,
                                  input int offset);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MU_Q16;
        i_cfg_data <= CFG_DATA_W'(mu);
        @(posedge i_clk);
        i_cfg_idx  <= REG_BRIGHT_FLOOR;
        i_cfg_data <= CFG_DATA_W'(floor_lvl);
        @(posedge i_clk);
        i_cfg_idx  <= REG_DARK_MARGIN;
        i_cfg_data <= CFG_DATA_W'(margin);
        @(posedge i_clk);
        i_cfg_idx  <= REG_RISE_OFFSET;
        i_cfg_data <= CFG_DATA_W'(offset);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(REG_MU_Q16, CFG_DATA_W'(mu));
        tracker.set_reg(REG_BRIGHT_FLOOR, CFG_DATA_W'(floor_lvl));
        tracker.set_reg(REG_DARK_MARGIN, CFG_DATA_W'(margin));
        tracker.set_reg(REG_RISE_OFFSET, CFG_DATA_W'(offset));
        settings_used++;
    endtask

    task automatic run_directed();
        int lvl;
        send_pixel(px(0, 0, 0, 1));
        send_pixel(px(255, 255, 255, 0));
        send_pixel(pixel_of_lum(int'(BRIGHT_FLOOR_RST), 0));
        send_pixel(pixel_of_lum(int'(BRIGHT_FLOOR_RST) + 1, 0));
        send_pixel(px(8'h55, 8'hAA, 8'h55, 0));
        send_pixel(px(8'hAA, 8'h55, 8'hAA, 0));
        // same position back to back: each beat must see the level just written
        repeat (3) send_pixel(px(255, 255, 255, 1));
        lvl = int'(tracker.next_level(1));
        send_pixel(pixel_of_lum(lvl - int'(DARK_MARGIN_RST), 1));
        send_pixel(pixel_of_lum(lvl - int'(DARK_MARGIN_RST) - 1, 1));
        lvl = int'(tracker.next_level(1));
        send_pixel(pixel_of_lum(lvl, 1));
        send_pixel(px(0, 0, 0, 1));
        send_pixel(px(255, 255, 255, 1));
        send_pixel(px(200, 200, 200, 0));
        send_pixel(px(0, 0, 0, 0));
        send_pixel(px(255, 255, 255, 1));
        send_pixel(px(0, 0, 9, 0));
        send_pixel(px(255, 0, 255, 0));
        send_pixel(px(255, 0, 255, 0));
        // restart mid-frame
        send_pixel(px(90, 90, 90, 1));
    endtask

    task automatic run_frames(input int beats);
        int          sent;
        int          frame_len;
        int unsigned roll;
        sent = 0;
        while (sent < beats) begin
            roll = $urandom_range(99);
            if (roll < 60)      frame_len = $urandom_range(6, 1);
            else if (roll < 92) frame_len = $urandom_range(60, 7);
            else                frame_len = $urandom_range(400, 61);
            // most frames open with a start; a few run on or restart midway
            for (int k = 0; k < frame_len && sent < beats; k++) begin
                send_pixel(random_pixel(k == 0 ? ($urandom_range(99) < 92)
                                               : ($urandom_range(99) < 3)));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_MU_Q16;
        i_cfg_data         = '0;
        pix.valid          = 1'b0;
        pix.chan_blue      = '0;
        pix.chan_green     = '0;
        pix.chan_red       = '0;
        pix.start_of_frame = 1'b0;
        res.ready          = 1'b0;
        send_idle_pct      = 17;
        recv_idle_pct      = 84;
        hold_requests      = 0;
        holds_taken        = 0;
        hold_left          = 0;
        quiet_cycles       = 0;
        settings_used      = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       apply_settings(65535, 0, 0, 255);
                1:       apply_settings(0, 765, 765, 0);
                default: apply_settings($urandom_range(65535), $urandom_range(600),
                                        $urandom_range(40), $urandom_range(255));
            endcase
            if (ph == 2) begin
                send_idle_pct = 84;
                recv_idle_pct <= 17;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                // back up the pipeline while the pixel side keeps offering
                hold_requests <= hold_requests + 1;
            end
            run_frames(PHASE_BEATS);
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d pixel beats under %0d register settings, with idling on each side",
                 tracker.n_pixels, settings_used);
        $display("and one long result stall: %0d white, %0d level drops, %0d frame ends.",
                 tracker.n_white, tracker.n_drop, tracker.n_eof);
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
